FILE: rtl/voxel_face_culling_macros.svh
// Assertion macros used by the voxel face culling RTL.
// Include-only header; no dependencies.
`ifndef VOXEL_FACE_CULLING_MACROS_SVH
`define VOXEL_FACE_CULLING_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define VFC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define VFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/vfc_pkg.sv
// Shared constants, codes and helper functions for the voxel face culling block.
// No dependencies; imported by voxel_face_culling, the checker and the testbench.
`timescale 1ns / 1ps

package vfc_pkg;

  // Chunk geometry
  localparam int WIDTH_X  = 16;
  localparam int DEPTH_Z  = 16;
  localparam int HEIGHT_Y = 256;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int SIDE_W  = 2;
  localparam int X_W     = 4;
  localparam int Y_W     = 8;
  localparam int Z_W     = 4;
  localparam int KIND_W  = 3;
  localparam int FACE_W  = 3;
  localparam int TILE_W  = 3;
  localparam int CNT_W   = 23;
  localparam int PRES_W  = 4;
  localparam int COL_W   = (X_W > Z_W) ? X_W : Z_W;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  localparam int NUM_FACES = 6;

  // Memory geometry
  localparam int VOX_DEPTH  = WIDTH_X * DEPTH_Z * HEIGHT_Y;
  localparam int VOX_AW     = $clog2(VOX_DEPTH);
  localparam int PLANE_W    = (WIDTH_X > DEPTH_Z) ? WIDTH_X : DEPTH_Z;
  localparam int BORD_DEPTH = 4 * HEIGHT_Y * PLANE_W;
  localparam int BORD_AW    = $clog2(BORD_DEPTH);

  localparam logic [CNT_W-1:0] VERTS_PER_FACE = CNT_W'(4);

  // Commands
  localparam logic [CMD_W-1:0] CMD_WR_VOX  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_BORD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd3;

  // Border sides
  localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_FRONT = 2'd2;
  localparam logic [SIDE_W-1:0] SIDE_BACK  = 2'd3;

  // Presence bits
  localparam int PRES_RIGHT = 0;
  localparam int PRES_LEFT  = 1;
  localparam int PRES_FRONT = 2;
  localparam int PRES_BACK  = 3;

  // Faces
  localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd0;
  localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd1;
  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd2;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd3;
  localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd4;
  localparam logic [FACE_W-1:0] FACE_BACK   = 3'd5;

  // Block kinds
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STONE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GRASS   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIRT    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WATER   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_GLASS   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SAND    = 3'd6;
  localparam logic [KIND_W-1:0] KIND_BEDROCK = 3'd7;

  // Atlas tiles
  localparam logic [TILE_W-1:0] TILE_GRASS_SIDE = 3'd0;
  localparam logic [TILE_W-1:0] TILE_GRASS_TOP  = 3'd1;
  localparam logic [TILE_W-1:0] TILE_DIRT       = 3'd2;
  localparam logic [TILE_W-1:0] TILE_STONE      = 3'd3;
  localparam logic [TILE_W-1:0] TILE_WATER      = 3'd4;
  localparam logic [TILE_W-1:0] TILE_GLASS      = 3'd5;
  localparam logic [TILE_W-1:0] TILE_SAND       = 3'd6;
  localparam logic [TILE_W-1:0] TILE_BEDROCK    = 3'd7;

  function automatic logic [VOX_AW-1:0] vox_addr(input logic [X_W-1:0] x,
                                                 input logic [Y_W-1:0] y,
                                                 input logic [Z_W-1:0] z);
    int a;
    a = (int'(x) * DEPTH_Z + int'(z)) * HEIGHT_Y + int'(y);
    return VOX_AW'(a);
  endfunction

  function automatic logic [BORD_AW-1:0] bord_addr(input logic [SIDE_W-1:0] side,
                                                   input logic [Y_W-1:0]    y,
                                                   input logic [COL_W-1:0]  col);
    int a;
    a = (int'(side) * HEIGHT_Y + int'(y)) * PLANE_W + int'(col);
    return BORD_AW'(a);
  endfunction

  function automatic logic is_clear(input logic [KIND_W-1:0] k);
    return (k == KIND_WATER) || (k == KIND_GLASS);
  endfunction

  function automatic logic reveals(input logic [KIND_W-1:0] cur,
                                   input logic [KIND_W-1:0] nb);
    logic r;
    if (cur == KIND_NONE) begin
      r = 1'b0;
    end else if (is_clear(cur)) begin
      r = (nb == KIND_NONE);
    end else begin
      r = (nb == KIND_NONE) || is_clear(nb);
    end
    return r;
  endfunction

  function automatic logic [TILE_W-1:0] tile_of(input logic [FACE_W-1:0] face,
                                                input logic [KIND_W-1:0] k);
    logic [TILE_W-1:0] t;
    case (k)
      KIND_STONE:   t = TILE_STONE;
      KIND_GRASS: begin
        if (face == FACE_TOP) begin
          t = TILE_GRASS_TOP;
        end else if (face == FACE_BOTTOM) begin
          t = TILE_DIRT;
        end else begin
          t = TILE_GRASS_SIDE;
        end
      end
      KIND_DIRT:    t = TILE_DIRT;
      KIND_WATER:   t = TILE_WATER;
      KIND_GLASS:   t = TILE_GLASS;
      KIND_SAND:    t = TILE_SAND;
      KIND_BEDROCK: t = TILE_BEDROCK;
      default:      t = TILE_GRASS_SIDE;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/vfc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module vfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/voxel_face_culling.sv
// Top level of the voxel face culling block: sequencer, counters and output register.
// Depends on vfc_pkg, vfc_ram and voxel_face_culling_macros.svh.
`timescale 1ns / 1ps
`include "voxel_face_culling_macros.svh"

// Voxel face culling. The block keeps one chunk of block kinds in a voxel
// memory and the facing planes of the four side neighbours in a border
// memory, both synchronous RAMs with one read port and a registered read.
// Write-voxel, write-border and start-mesh transactions complete in S_IDLE.
// A query is accepted in S_IDLE, reads the queried voxel in S_CUR and, when
// that voxel is not empty, reads its neighbours right, left, top, bottom,
// front, back one after another in S_NB through the read ports, then hands
// out one revealed face per cycle while the output side takes them; an
// empty voxel ends the query after S_CUR. The output register lets the
// next transaction enter while the last face still waits. A side whose
// presence bit is clear reads as empty; the top and bottom of the chunk
// always show. base_vertex is the opaque or transparent vertex counter before
// the face; each face advances its counter by four, and start-mesh clears
// both. Entries read before they are written give undefined faces. No
// memory clearing pass is needed after reset.
module voxel_face_culling (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration: neighbour_present
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vfc_pkg::PRES_W-1:0]         cfg_data,
  // Input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // side[1:0], pos_x[5:2], pos_y[13:6], pos_z[17:14], block_kind[20:18], zero fill
  input  logic [vfc_pkg::IN_DATA_W-1:0]      s_tdata,
  // cmd[1:0]
  input  logic [vfc_pkg::CMD_W-1:0]          s_tuser,
  // Output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // face[2:0], tile[5:3], face_x[9:6], face_y[17:10], face_z[21:18],
  // base_vertex[44:22], zero fill
  output logic [vfc_pkg::OUT_DATA_W-1:0]     m_tdata,
  // transparent[0]
  output logic                               m_tuser,
  output logic                               m_tlast
);

  import vfc_pkg::*;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // take transactions
  localparam logic [1:0] S_CUR  = 2'd1;  // queried voxel arrives
  localparam logic [1:0] S_NB   = 2'd2;  // neighbours arrive, one per cycle
  localparam logic [1:0] S_EMIT = 2'd3;  // hand out revealed faces

  // Where a neighbour read comes from
  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_VOX  = 2'd1;
  localparam logic [1:0] SRC_BORD = 2'd2;

  localparam logic [2:0] LAST_NB = 3'(NUM_FACES - 1);

  // Input field decode
  logic [SIDE_W-1:0] in_side;
  logic [X_W-1:0]    in_x;
  logic [Y_W-1:0]    in_y;
  logic [Z_W-1:0]    in_z;
  logic [KIND_W-1:0] in_kind;
  logic [CMD_W-1:0]  in_cmd;

  assign in_side = s_tdata[1:0];
  assign in_x    = s_tdata[5:2];
  assign in_y    = s_tdata[13:6];
  assign in_z    = s_tdata[17:14];
  assign in_kind = s_tdata[20:18];
  assign in_cmd  = s_tuser;

  logic [1:0]            state;
  logic [2:0]            nb_idx;
  logic [NUM_FACES-1:0]  mask;
  logic [1:0]            rd_src;
  logic [PRES_W-1:0]     present;
  logic [CNT_W-1:0]      opaque_count;
  logic [CNT_W-1:0]      clear_count;

  // Query payload, held for the whole query
  logic [X_W-1:0]    qx;
  logic [Y_W-1:0]    qy;
  logic [Z_W-1:0]    qz;
  logic [KIND_W-1:0] cur;

  // Output register
  logic [FACE_W-1:0] o_face;
  logic [TILE_W-1:0] o_tile;
  logic              o_clear;
  logic [X_W-1:0]    o_x;
  logic [Y_W-1:0]    o_y;
  logic [Z_W-1:0]    o_z;
  logic [CNT_W-1:0]  o_base;
  logic              o_last;

  logic accept;
  logic in_range;
  logic bord_ok;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign in_range = (int'(in_x) < WIDTH_X) && (int'(in_y) < HEIGHT_Y) &&
                    (int'(in_z) < DEPTH_Z);
  assign bord_ok  = (int'(in_y) < HEIGHT_Y) &&
                    (((in_side == SIDE_RIGHT) || (in_side == SIDE_LEFT)) ?
                     (int'(in_z) < DEPTH_Z) : (int'(in_x) < WIDTH_X));

  // Memories
  logic               vox_we;
  logic [VOX_AW-1:0]  vox_waddr;
  logic [VOX_AW-1:0]  vox_raddr;
  logic [KIND_W-1:0]  vox_rdata;
  logic               bord_we;
  logic [BORD_AW-1:0] bord_waddr;
  logic [BORD_AW-1:0] bord_raddr;
  logic [KIND_W-1:0]  bord_rdata;
  logic [COL_W-1:0]   in_col;

  assign vox_we    = accept && (in_cmd == CMD_WR_VOX) && in_range;
  assign vox_waddr = vox_addr(in_x, in_y, in_z);

  assign in_col     = ((in_side == SIDE_RIGHT) || (in_side == SIDE_LEFT)) ?
                      COL_W'(in_z) : COL_W'(in_x);
  assign bord_we    = accept && (in_cmd == CMD_WR_BORD) && bord_ok;
  assign bord_waddr = bord_addr(in_side, in_y, in_col);

  // Neighbour read issue: index 0 from S_CUR, then one more per S_NB cycle
  logic [2:0]         issue_idx;
  logic [1:0]         issue_src;
  logic [VOX_AW-1:0]  issue_vaddr;
  logic [BORD_AW-1:0] issue_baddr;

  assign issue_idx = (state == S_CUR) ? 3'd0 : nb_idx + 3'd1;

  always_comb begin
    issue_src   = SRC_VOX;
    issue_vaddr = vox_addr(qx, qy, qz);
    issue_baddr = bord_addr(SIDE_RIGHT, qy, COL_W'(qz));
    case (issue_idx)
      3'(FACE_RIGHT): begin
        issue_vaddr = vox_addr(qx + X_W'(1), qy, qz);
        issue_baddr = bord_addr(SIDE_RIGHT, qy, COL_W'(qz));
        if (int'(qx) == WIDTH_X - 1) begin
          issue_src = present[PRES_RIGHT] ? SRC_BORD : SRC_ZERO;
        end
      end
      3'(FACE_LEFT): begin
        issue_vaddr = vox_addr(qx - X_W'(1), qy, qz);
        issue_baddr = bord_addr(SIDE_LEFT, qy, COL_W'(qz));
        if (qx == '0) begin
          issue_src = present[PRES_LEFT] ? SRC_BORD : SRC_ZERO;
        end
      end
      3'(FACE_TOP): begin
        issue_vaddr = vox_addr(qx, qy + Y_W'(1), qz);
        if (int'(qy) == HEIGHT_Y - 1) begin
          issue_src = SRC_ZERO;
        end
      end
      3'(FACE_BOTTOM): begin
        issue_vaddr = vox_addr(qx, qy - Y_W'(1), qz);
        if (qy == '0) begin
          issue_src = SRC_ZERO;
        end
      end
      3'(FACE_FRONT): begin
        issue_vaddr = vox_addr(qx, qy, qz + Z_W'(1));
        issue_baddr = bord_addr(SIDE_FRONT, qy, COL_W'(qx));
        if (int'(qz) == DEPTH_Z - 1) begin
          issue_src = present[PRES_FRONT] ? SRC_BORD : SRC_ZERO;
        end
      end
      3'(FACE_BACK): begin
        issue_vaddr = vox_addr(qx, qy, qz - Z_W'(1));
        issue_baddr = bord_addr(SIDE_BACK, qy, COL_W'(qx));
        if (qz == '0) begin
          issue_src = present[PRES_BACK] ? SRC_BORD : SRC_ZERO;
        end
      end
      default: begin
        issue_src = SRC_ZERO;
      end
    endcase
  end

  // Accepted queries read the voxel straight from the input fields.
  // Writes land before any later read, so no forwarding is needed.
  assign vox_raddr  = (state == S_IDLE) ? vox_addr(in_x, in_y, in_z) : issue_vaddr;
  assign bord_raddr = issue_baddr;

  vfc_ram #(
    .WIDTH (KIND_W),
    .DEPTH (VOX_DEPTH)
  ) u_vox_ram (
    .clk   (clk),
    .we    (vox_we),
    .waddr (vox_waddr),
    .wdata (in_kind),
    .raddr (vox_raddr),
    .rdata (vox_rdata)
  );

  vfc_ram #(
    .WIDTH (KIND_W),
    .DEPTH (BORD_DEPTH)
  ) u_bord_ram (
    .clk   (clk),
    .we    (bord_we),
    .waddr (bord_waddr),
    .wdata (in_kind),
    .raddr (bord_raddr),
    .rdata (bord_rdata)
  );

  // Neighbour value and reveal decision for the read that arrives now
  logic [KIND_W-1:0]    nb_kind;
  logic                 show;
  logic [NUM_FACES-1:0] mask_next;

  always_comb begin
    case (rd_src)
      SRC_VOX:  nb_kind = vox_rdata;
      SRC_BORD: nb_kind = bord_rdata;
      default:  nb_kind = KIND_NONE;
    endcase
  end

  assign show      = reveals(cur, nb_kind);
  assign mask_next = mask | (NUM_FACES'(show) << nb_idx);

  // Face selection: lowest pending face first
  logic [FACE_W-1:0]    sel_face;
  logic [NUM_FACES-1:0] remaining;
  logic                 load;
  logic                 sel_clear;

  always_comb begin
    sel_face = FACE_RIGHT;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel_face = FACE_W'(i);
      end
    end
  end

  assign remaining = mask & ~(NUM_FACES'(1) << sel_face);
  assign load      = (state == S_EMIT) && (!m_tvalid || m_tready);
  assign sel_clear = is_clear(cur);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      nb_idx       <= '0;
      mask         <= '0;
      rd_src       <= SRC_ZERO;
      present      <= '0;
      opaque_count <= '0;
      clear_count  <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        present <= cfg_data;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_cmd == CMD_START) begin
              opaque_count <= '0;
              clear_count  <= '0;
            end
            if ((in_cmd == CMD_QUERY) && in_range) begin
              state <= S_CUR;
            end
          end
        end
        S_CUR: begin
          mask   <= '0;
          nb_idx <= '0;
          rd_src <= issue_src;
          // drop the query when the voxel is empty
          state  <= (vox_rdata == KIND_NONE) ? S_IDLE : S_NB;
        end
        S_NB: begin
          mask   <= mask_next;
          rd_src <= issue_src;
          if (nb_idx == LAST_NB) begin
            state <= (mask_next == '0) ? S_IDLE : S_EMIT;
          end else begin
            nb_idx <= nb_idx + 3'd1;
          end
        end
        S_EMIT: begin
          if (load) begin
            mask <= remaining;
            if (sel_clear) begin
              clear_count <= clear_count + VERTS_PER_FACE;
            end else begin
              opaque_count <= opaque_count + VERTS_PER_FACE;
            end
            if (remaining == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload: query coordinates, current voxel and output fields
  always_ff @(posedge clk) begin
    if (accept) begin
      qx <= in_x;
      qy <= in_y;
      qz <= in_z;
    end
    if (state == S_CUR) begin
      cur <= vox_rdata;
    end
    if (load) begin
      o_face  <= sel_face;
      o_tile  <= tile_of(sel_face, cur);
      o_clear <= sel_clear;
      o_x     <= qx;
      o_y     <= qy;
      o_z     <= qz;
      o_base  <= sel_clear ? clear_count : opaque_count;
      o_last  <= (remaining == '0);
    end
  end

  assign m_tdata = {3'b000, o_base, o_z, o_y, o_x, o_tile, o_face};
  assign m_tuser = o_clear;
  assign m_tlast = o_last;

  // Assertions
  `VFC_ASSERT_SAME(a_emit_nonempty, clk, rst, state == S_EMIT, (cur != KIND_NONE) && (mask != '0), "face emission with empty voxel or no pending face")
  `VFC_ASSERT_NEXT(a_last_ends_query, clk, rst, load && (remaining == '0), (state == S_IDLE) && m_tvalid && m_tlast, "final face did not close the query")
  `VFC_ASSERT_NEXT(a_opaque_step, clk, rst, load && !sel_clear, opaque_count == $past(opaque_count) + VERTS_PER_FACE, "opaque counter did not advance by one face")

endmodule

FILE: bench/voxel_face_culling_checker.sv
// Scoreboard for the voxel face culling block: mirrors the chunk, borders and counters.
// Watches the configuration, input and output channels; depends on vfc_pkg.
`timescale 1ns / 1ps

module face_cull_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [vfc_pkg::PRES_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [vfc_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [vfc_pkg::CMD_W-1:0]      s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [vfc_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           m_tuser,
  input  logic                           m_tlast,
  output int                             failures,
  output int                             pending,
  output int                             faces_checked
);

  import vfc_pkg::*;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [TILE_W-1:0] tile;
    logic              clear;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [Z_W-1:0]    z;
    logic [CNT_W-1:0]  base;
    logic              last;
  } face_t;

  // Mirrored chunk: voxels by {x, z, y}, side planes by {y, z}, front/back by {y, x}
  logic [KIND_W-1:0] voxels      [0:65535];
  logic [KIND_W-1:0] right_plane [0:4095];
  logic [KIND_W-1:0] left_plane  [0:4095];
  logic [KIND_W-1:0] front_plane [0:4095];
  logic [KIND_W-1:0] back_plane  [0:4095];

  logic [PRES_W-1:0] presence;
  logic [CNT_W-1:0]  opaque_next;
  logic [CNT_W-1:0]  clear_next;
  face_t             expected_faces [$];
  face_t             want;
  int                errors;
  int                checked;

  function automatic logic see_through(input logic [KIND_W-1:0] k);
    return (k == KIND_WATER) || (k == KIND_GLASS);
  endfunction

  function automatic logic [TILE_W-1:0] atlas_tile(input int f, input logic [KIND_W-1:0] k);
    logic [TILE_W-1:0] t;
    t = TILE_GRASS_SIDE;
    case (k)
      KIND_STONE:   t = TILE_STONE;
      KIND_GRASS: begin
        if (f == FACE_TOP) t = TILE_GRASS_TOP;
        else if (f == FACE_BOTTOM) t = TILE_DIRT;
      end
      KIND_DIRT:    t = TILE_DIRT;
      KIND_WATER:   t = TILE_WATER;
      KIND_GLASS:   t = TILE_GLASS;
      KIND_SAND:    t = TILE_SAND;
      KIND_BEDROCK: t = TILE_BEDROCK;
      default:      t = TILE_GRASS_SIDE;
    endcase
    return t;
  endfunction

  function automatic int field_differs(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  // Work out the faces that one query reveals and queue them in order
  task automatic predict_faces(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                               input logic [Z_W-1:0] z);
    logic [KIND_W-1:0] cur;
    logic [KIND_W-1:0] nb [6];
    face_t             hit [6];
    int                n;
    logic              show;
    logic              clr;
    n   = 0;
    cur = voxels[{x, z, y}];
    if (cur != KIND_NONE) begin
      if (x == WIDTH_X - 1)
        nb[0] = presence[PRES_RIGHT] ? right_plane[{y, z}] : KIND_NONE;
      else
        nb[0] = voxels[{x + 4'd1, z, y}];
      if (x == 0)
        nb[1] = presence[PRES_LEFT] ? left_plane[{y, z}] : KIND_NONE;
      else
        nb[1] = voxels[{x - 4'd1, z, y}];
      nb[2] = (y == HEIGHT_Y - 1) ? KIND_NONE : voxels[{x, z, y + 8'd1}];
      nb[3] = (y == 0) ? KIND_NONE : voxels[{x, z, y - 8'd1}];
      if (z == DEPTH_Z - 1)
        nb[4] = presence[PRES_FRONT] ? front_plane[{y, x}] : KIND_NONE;
      else
        nb[4] = voxels[{x, z + 4'd1, y}];
      if (z == 0)
        nb[5] = presence[PRES_BACK] ? back_plane[{y, x}] : KIND_NONE;
      else
        nb[5] = voxels[{x, z - 4'd1, y}];
      clr = see_through(cur);
      for (int f = 0; f < NUM_FACES; f++) begin
        // chunk top and bottom always show
        if (f == FACE_TOP && y == HEIGHT_Y - 1) show = 1'b1;
        else if (f == FACE_BOTTOM && y == 0) show = 1'b1;
        else if (clr) show = (nb[f] == KIND_NONE);
        else show = (nb[f] == KIND_NONE) || see_through(nb[f]);
        if (show) begin
          hit[n].face  = FACE_W'(f);
          hit[n].tile  = atlas_tile(f, cur);
          hit[n].clear = clr;
          hit[n].x     = x;
          hit[n].y     = y;
          hit[n].z     = z;
          hit[n].last  = 1'b0;
          if (clr) begin
            hit[n].base = clear_next;
            clear_next  = clear_next + CNT_W'(4);
          end else begin
            hit[n].base = opaque_next;
            opaque_next = opaque_next + CNT_W'(4);
          end
          n++;
        end
      end
    end
    for (int j = 0; j < n; j++) begin
      if (j == n - 1) hit[j].last = 1'b1;
      expected_faces.insert(expected_faces.size(), hit[j]);
    end
  endtask

  task automatic apply_item(input logic [CMD_W-1:0] cmd, input logic [IN_DATA_W-1:0] data);
    logic [SIDE_W-1:0] side;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [Z_W-1:0]    z;
    logic [KIND_W-1:0] kind;
    side = data[1:0];
    x    = data[5:2];
    y    = data[13:6];
    z    = data[17:14];
    kind = data[20:18];
    case (cmd)
      CMD_START: begin
        opaque_next = '0;
        clear_next  = '0;
      end
      CMD_WR_VOX: voxels[{x, z, y}] = kind;
      CMD_WR_BORD: begin
        case (side)
          SIDE_RIGHT: right_plane[{y, z}] = kind;
          SIDE_LEFT:  left_plane[{y, z}]  = kind;
          SIDE_FRONT: front_plane[{y, x}] = kind;
          default:    back_plane[{y, x}]  = kind;
        endcase
      end
      default: predict_faces(x, y, z);
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      presence    = '0;
      opaque_next = '0;
      clear_next  = '0;
      expected_faces.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_faces.size() == 0) begin
          $error("face result with nothing expected: tdata=%h tuser=%b tlast=%b",
                 m_tdata, m_tuser, m_tlast);
          errors++;
        end else begin
          want = expected_faces.pop_front();
          errors += field_differs("face", want.face, m_tdata[2:0]);
          errors += field_differs("tile", want.tile, m_tdata[5:3]);
          errors += field_differs("transparent", want.clear, m_tuser);
          errors += field_differs("face_x", want.x, m_tdata[9:6]);
          errors += field_differs("face_y", want.y, m_tdata[17:10]);
          errors += field_differs("face_z", want.z, m_tdata[21:18]);
          errors += field_differs("base_vertex", want.base, m_tdata[44:22]);
          errors += field_differs("last", want.last, m_tlast);
          checked++;
        end
      end
      if (cfg_valid && cfg_ready) presence = cfg_data;
      if (s_tvalid && s_tready) apply_item(s_tuser, s_tdata);
    end
    failures      <= errors;
    pending       <= expected_faces.size();
    faces_checked <= checked;
  end

endmodule

FILE: bench/testbench.sv
// Top of the voxel face culling bench: clock, reset, stimulus and verdict.
// Depends on vfc_pkg, voxel_face_culling and face_cull_checker.
`timescale 1ns / 1ps

module testbench;
  import vfc_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  // cycles a trailing write may still occupy the block after the last face
  localparam int SETTLE_CYCLES = 20;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [PRES_W-1:0]     cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [CMD_W-1:0]      s_tuser   = CMD_START;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  int failures;
  int pending;
  int faces_checked;
  int cycle_count  = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int items_sent   = 0;
  int queries_sent = 0;

  // Entries already written, so that no query ever reads an unwritten one
  bit vox_done  [0:65535];
  bit bord_done [4][4096];

  voxel_face_culling uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  face_cull_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .failures      (failures),
    .pending       (pending),
    .faces_checked (faces_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Stall the output side at random; hold it low through reset
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (int'($urandom_range(99)) >= rx_idle_pct);
    end
  end

  // Abandon the run if it hangs
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [KIND_W-1:0] pick_kind();
    // favour empty cells so that plenty of faces show
    if ($urandom_range(2) == 0) return KIND_NONE;
    return KIND_W'($urandom_range(1, 7));
  endfunction

  function automatic int jitter(input int c, input int hi);
    int v;
    v = c + int'($urandom_range(2)) - 1;
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v;
  endfunction

  // Present one transaction, idling beforehand at the current rate, and hold it until taken
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SIDE_W-1:0] side,
                           input int x, input int y, input int z,
                           input logic [KIND_W-1:0] kind);
    while (int'($urandom_range(99)) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, kind, Z_W'(z), Y_W'(y), X_W'(x), side};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (cmd == CMD_WR_VOX) vox_done[{X_W'(x), Z_W'(z), Y_W'(y)}] = 1'b1;
    if (cmd == CMD_WR_BORD) begin
      if (side == SIDE_RIGHT || side == SIDE_LEFT)
        bord_done[side][{Y_W'(y), Z_W'(z)}] = 1'b1;
      else
        bord_done[side][{Y_W'(y), X_W'(x)}] = 1'b1;
    end
  endtask

  task automatic ensure_voxel(input int x, input int y, input int z);
    if (!vox_done[{X_W'(x), Z_W'(z), Y_W'(y)}])
      send_item(CMD_WR_VOX, SIDE_W'($urandom), x, y, z, pick_kind());
  endtask

  // col is z for the right and left planes, x for the front and back planes
  task automatic ensure_plane(input logic [SIDE_W-1:0] side, input int y, input int col);
    if (!bord_done[side][{Y_W'(y), 4'(col)}]) begin
      if (side == SIDE_RIGHT || side == SIDE_LEFT)
        send_item(CMD_WR_BORD, side, $urandom_range(15), y, col, pick_kind());
      else
        send_item(CMD_WR_BORD, side, col, y, $urandom_range(15), pick_kind());
    end
  endtask

  // Fill in whatever the query may read, then issue it
  task automatic query_voxel(input int x, input int y, input int z);
    ensure_voxel(x, y, z);
    if (x < WIDTH_X - 1) ensure_voxel(x + 1, y, z);
    else ensure_plane(SIDE_RIGHT, y, z);
    if (x > 0) ensure_voxel(x - 1, y, z);
    else ensure_plane(SIDE_LEFT, y, z);
    if (y < HEIGHT_Y - 1) ensure_voxel(x, y + 1, z);
    if (y > 0) ensure_voxel(x, y - 1, z);
    if (z < DEPTH_Z - 1) ensure_voxel(x, y, z + 1);
    else ensure_plane(SIDE_FRONT, y, x);
    if (z > 0) ensure_voxel(x, y, z - 1);
    else ensure_plane(SIDE_BACK, y, x);
    send_item(CMD_QUERY, SIDE_W'($urandom), x, y, z, KIND_W'($urandom));
    queries_sent++;
  endtask

  // Drop valid and hold until every expected face has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_presence(input logic [PRES_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly queries and rewrites around a moving hot spot, plus scattered noise;
  // run until quota more transactions have gone in
  task automatic random_phase(input int quota);
    int ox;
    int oy;
    int oz;
    int r;
    int stop_at;
    bit drained;
    logic [SIDE_W-1:0] sd;
    ox = 0;
    oy = 0;
    oz = 0;
    stop_at = items_sent + quota;
    drained = 1'b0;
    for (int i = 0; items_sent < stop_at; i++) begin
      if (i % 20 == 0) begin
        if ($urandom_range(1)) begin
          // hug the chunk edges so border planes and top/bottom get exercised
          ox = $urandom_range(1) ? 15 : 0;
          oy = $urandom_range(1) ? 255 : 0;
          oz = $urandom_range(1) ? 15 : 0;
        end else begin
          ox = $urandom_range(15);
          oy = $urandom_range(255);
          oz = $urandom_range(15);
        end
      end
      if (!drained && (items_sent >= stop_at - quota / 2)) begin
        wait_drained();
        drained = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 50) begin
        query_voxel(jitter(ox, 15), jitter(oy, 255), jitter(oz, 15));
      end else if (r < 70) begin
        send_item(CMD_WR_VOX, SIDE_W'($urandom), jitter(ox, 15), jitter(oy, 255),
                  jitter(oz, 15), pick_kind());
      end else if (r < 77) begin
        sd = SIDE_W'($urandom);
        send_item(CMD_WR_BORD, sd, jitter(ox, 15), jitter(oy, 255), jitter(oz, 15),
                  pick_kind());
      end else if (r < 87) begin
        send_item(CMD_WR_VOX, SIDE_W'($urandom), $urandom_range(15), $urandom_range(255),
                  $urandom_range(15), KIND_W'($urandom));
      end else if (r < 92) begin
        send_item(CMD_WR_BORD, SIDE_W'($urandom), $urandom_range(15), $urandom_range(255),
                  $urandom_range(15), KIND_W'($urandom));
      end else if (r < 95) begin
        send_item(CMD_START, SIDE_W'($urandom), $urandom_range(15), $urandom_range(255),
                  $urandom_range(15), KIND_W'($urandom));
      end else begin
        query_voxel($urandom_range(15), $urandom_range(255), $urandom_range(15));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 25;
    rx_idle_pct = 60;
    write_presence(4'b0000);

    // Directed: every command, all neighbour chunks absent
    // start with every ignored field set
    send_item(CMD_START, SIDE_BACK, 15, 255, 15, KIND_BEDROCK);
    // grass at the far top corner: opaque against water and glass, top always shows
    send_item(CMD_WR_VOX, SIDE_RIGHT, 15, 255, 15, KIND_GRASS);
    send_item(CMD_WR_VOX, SIDE_LEFT, 14, 255, 15, KIND_WATER);
    send_item(CMD_WR_VOX, SIDE_FRONT, 15, 254, 15, KIND_GLASS);
    send_item(CMD_WR_VOX, SIDE_BACK, 15, 255, 14, KIND_NONE);
    send_item(CMD_WR_BORD, SIDE_RIGHT, 0, 255, 15, KIND_STONE);
    send_item(CMD_WR_BORD, SIDE_FRONT, 15, 255, 0, KIND_WATER);
    query_voxel(15, 255, 15);
    // water at the origin: hidden by stone and glass, bottom always shows
    send_item(CMD_WR_VOX, SIDE_RIGHT, 0, 0, 0, KIND_WATER);
    send_item(CMD_WR_VOX, SIDE_RIGHT, 1, 0, 0, KIND_STONE);
    send_item(CMD_WR_VOX, SIDE_RIGHT, 0, 1, 0, KIND_NONE);
    send_item(CMD_WR_VOX, SIDE_RIGHT, 0, 0, 1, KIND_GLASS);
    send_item(CMD_WR_BORD, SIDE_LEFT, 15, 0, 0, KIND_DIRT);
    send_item(CMD_WR_BORD, SIDE_BACK, 0, 0, 15, KIND_SAND);
    query_voxel(0, 0, 0);
    // empty voxel gives nothing
    query_voxel(0, 1, 0);

    // Random: all neighbours present, then two mixed settings
    write_presence(4'b1111);
    random_phase(80);

    tx_idle_pct = 60;
    rx_idle_pct = 25;
    write_presence(4'b1010);
    random_phase(80);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_presence(4'b0101);
    random_phase(80);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d transactions, %0d of them queries, across presence masks 0, F, A, 5.",
             items_sent, queries_sent);
    $display("Checked %0d face results field by field.", faces_checked);
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/vfc_pkg.sv
rtl/vfc_ram.sv
rtl/voxel_face_culling.sv
bench/voxel_face_culling_checker.sv
bench/testbench.sv
